/* rtl/core/pwl_pkg.sv */
// Package with shared types and constants of the piecewise linear evaluator.
`timescale 1ns / 1ps
package pwl_pkg;
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_EVAL  = 2'd1,
    OP_INV   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;
  localparam int QW = 32;
  localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN = -64'sd2147483648;
endpackage

/* rtl/core/pwl_ram.sv */
// Generic single-port-write, one-read RAM with a registered read.
`timescale 1ns / 1ps
module pwl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/piecewise_linear_eval_inverse.sv */
// Top level of the piecewise linear evaluator with inverse lookup.
// A request is taken when start is high and busy is low; busy stays high until its single
// result strobes out on out_valid for one cycle, and the receiver cannot stall it. A write
// completes without scanning the table. An evaluate scans the breakpoints with the table
// memories read one entry at a time, then uses a registered multiplier. An inverse also
// scans the breakpoints one entry at a time and then runs a restoring divider.
// breakpoint_count may only be written while busy is low.
`timescale 1ns / 1ps
module piecewise_linear_eval_inverse
  import pwl_pkg::*;
#(
  parameter int MAX_BREAKPOINTS = 15
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_op,
  input  logic [3:0]               in_entry_index,
  input  logic signed [QW-1:0]     in_breakpoint_value,
  input  logic signed [QW-1:0]     in_segment_offset,
  input  logic signed [QW-1:0]     in_segment_slope,
  input  logic signed [QW-1:0]     in_query_value,
  output logic                     out_valid,
  output logic signed [QW-1:0]     out_result_value,
  output logic                     out_undefined_flag,
  output logic                     out_saturated_flag,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [3:0]               cfg_breakpoint_count
);
  localparam int DEPTH = MAX_BREAKPOINTS + 1;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(MAX_BREAKPOINTS + 1) > 4 ? $clog2(MAX_BREAKPOINTS + 1) : 4;

  typedef enum logic [3:0] {
    S_IDLE, S_EV_RD, S_EV_CMP, S_EV_MUL, S_EV_ADD,
    S_IN_RD, S_IN_MUL, S_IN_ADD, S_IN_CMP, S_DV_RD, S_DV_SET, S_DV_RUN, S_DV_FIN, S_DONE
  } state_t;

  state_t state_r;
  logic [3:0] count_r;
  logic [CW-1:0] idx_r;
  logic signed [QW-1:0] q_r, bp_r, bp_prev_r, res_r;
  logic signed [63:0] prod_r;
  logic und_r, sat_r, valid_r;
  logic [AW-1:0] bp_raddr, seg_raddr, waddr;
  logic bp_we, seg_we;
  logic signed [QW-1:0] bp_rd, off_rd, slp_rd;
  logic [CW-1:0] n_used;
  logic neg_r;
  logic [63:0] dvd_r, dvs_r, quo_r;
  logic [5:0] step_r;
  logic [47:0] rem_r;
  logic signed [64:0] sum;
  logic signed [63:0] fl;
  logic [48:0] trial;
  logic signed [64:0] qsgn;
  logic signed [QW-1:0] h_clip, fin_val;
  logic h_sat, fin_sat;

  assign n_used = (CW'(count_r) > CW'(MAX_BREAKPOINTS)) ? CW'(MAX_BREAKPOINTS) : CW'(count_r);
  assign busy = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign out_valid = valid_r;
  assign out_result_value = res_r;
  assign out_undefined_flag = und_r;
  assign out_saturated_flag = sat_r;

  assign waddr = AW'(in_entry_index);
  assign seg_we = start && !busy && (in_op == OP_WRITE)
                  && (32'(in_entry_index) <= 32'(MAX_BREAKPOINTS));
  assign bp_we = seg_we && (32'(in_entry_index) < 32'(MAX_BREAKPOINTS));

  pwl_ram #(.WIDTH(QW), .DEPTH(DEPTH)) u_bp (
    .clk, .we(bp_we), .waddr, .wdata(in_breakpoint_value), .raddr(bp_raddr), .rdata(bp_rd));
  pwl_ram #(.WIDTH(QW), .DEPTH(DEPTH)) u_off (
    .clk, .we(seg_we), .waddr, .wdata(in_segment_offset), .raddr(seg_raddr), .rdata(off_rd));
  pwl_ram #(.WIDTH(QW), .DEPTH(DEPTH)) u_slp (
    .clk, .we(seg_we), .waddr, .wdata(in_segment_slope), .raddr(seg_raddr), .rdata(slp_rd));

  always_comb begin
    bp_raddr = AW'(idx_r);
    seg_raddr = AW'(idx_r);
    if (state_r == S_IN_RD || state_r == S_IN_MUL) begin
      seg_raddr = AW'(idx_r + 1'b1);
    end
  end

  // Floor of the product over 2^16, then offset added.
  assign fl = prod_r >>> 16;
  assign sum = 65'(off_rd) + 65'(fl);
  assign trial = {rem_r, dvd_r[63]} ;
  assign qsgn = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

  // The quotient is clipped first; each clamp then replaces the clipped height.
  always_comb begin
    h_sat = 1'b0;
    h_clip = qsgn[QW-1:0];
    if (qsgn > 65'(Q_MAX)) begin
      h_clip = Q_MAX[QW-1:0];
      h_sat = 1'b1;
    end else if (qsgn < 65'(Q_MIN)) begin
      h_clip = Q_MIN[QW-1:0];
      h_sat = 1'b1;
    end
    fin_val = h_clip;
    fin_sat = h_sat;
    if (idx_r < n_used && h_clip > bp_r) begin
      fin_val = bp_r;
      fin_sat = 1'b0;
    end
    if (idx_r != '0 && fin_val < bp_prev_r) begin
      fin_val = bp_prev_r;
      fin_sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_breakpoint_count;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            q_r <= in_query_value;
            idx_r <= '0;
            und_r <= 1'b0;
            sat_r <= 1'b0;
            res_r <= '0;
            unique case (op_t'(in_op))
              OP_EVAL: state_r <= S_EV_RD;
              OP_INV: state_r <= S_IN_RD;
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_EV_RD: state_r <= S_EV_CMP;
        S_EV_CMP: begin
          if (idx_r < n_used && bp_rd < q_r) begin
            idx_r <= idx_r + 1'b1;
            state_r <= S_EV_RD;
          end else begin
            state_r <= S_EV_MUL;
          end
        end
        S_EV_MUL: begin
          prod_r <= 64'(slp_rd) * 64'(q_r);
          state_r <= S_EV_ADD;
        end
        S_EV_ADD: begin
          if (sum > 65'(Q_MAX)) begin
            res_r <= Q_MAX[31:0]; sat_r <= 1'b1;
          end else if (sum < 65'(Q_MIN)) begin
            res_r <= Q_MIN[31:0]; sat_r <= 1'b1;
          end else begin
            res_r <= sum[31:0];
          end
          state_r <= S_DONE;
        end
        S_IN_RD: begin
          if (idx_r < n_used) begin
            state_r <= S_IN_MUL;
          end else begin
            state_r <= S_DV_RD;
          end
        end
        S_IN_MUL: begin
          bp_r <= bp_rd;
          prod_r <= 64'(slp_rd) * 64'(bp_rd);
          state_r <= S_IN_ADD;
        end
        S_IN_ADD: begin
          if (sum < 65'(q_r) && q_r != Q_MIN[QW-1:0]) begin
            state_r <= S_DV_RD;
          end else begin
            bp_prev_r <= bp_r;
            idx_r <= idx_r + 1'b1;
            state_r <= S_IN_CMP;
          end
        end
        S_IN_CMP: state_r <= S_IN_RD;
        S_DV_RD: state_r <= S_DV_SET;
        S_DV_SET: begin
          if (slp_rd == '0) begin
            und_r <= 1'b1;
            state_r <= S_DONE;
          end else begin
            dvd_r <= ((64'(q_r) - 64'(off_rd)) < 0) ? 64'(-((64'(q_r) - 64'(off_rd)) <<< 16))
                                                   : 64'((64'(q_r) - 64'(off_rd)) <<< 16);
            dvs_r <= slp_rd[31] ? 64'(-64'(slp_rd)) : 64'(slp_rd);
            neg_r <= ((64'(q_r) - 64'(off_rd)) < 0) ^ slp_rd[31];
            quo_r <= '0;
            rem_r <= '0;
            step_r <= '0;
            state_r <= S_DV_RUN;
          end
        end
        S_DV_RUN: begin
          if (trial >= 49'(dvs_r)) begin
            rem_r <= 48'(trial - 49'(dvs_r));
            quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= trial[47:0];
            quo_r <= {quo_r[62:0], 1'b0};
          end
          dvd_r <= {dvd_r[62:0], 1'b0};
          step_r <= step_r + 1'b1;
          if (step_r == 6'd63) begin
            state_r <= S_DV_FIN;
          end
        end
        S_DV_FIN: begin
          res_r <= fin_val;
          sat_r <= fin_sat;
          state_r <= S_DONE;
        end
        S_DONE: begin
          valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/core/pwl_checker.sv */
// Port-level assertions for the piecewise linear evaluator, bound to the top level.
`timescale 1ns / 1ps
module pwl_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_undefined_flag,
  input logic out_saturated_flag,
  input logic signed [31:0] out_result_value,
  input logic cfg_ready
);
  a_take: assert property (@(posedge clk) disable iff (!rst_n) start && !busy |=> busy)
    else $error("Request did not raise busy.");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_undefined_flag |-> !out_saturated_flag && out_result_value == 0)
    else $error("Undefined result carries a value.");
  a_end: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !busy)
    else $error("Result shown while busy.");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready == !busy)
    else $error("Configuration ready while busy.");
endmodule

bind piecewise_linear_eval_inverse pwl_checker u_pwl_checker (.*);
